### rtl/tcw_pkg.sv
package tcw_pkg;

  // payload field widths
  localparam int REQ_W   = 1;
  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 11;
  localparam int CCOL_W  = 7;
  localparam int CROW_W  = 5;
  localparam int CELL_W  = 16;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_PUT  = 1'b0;
  localparam logic [REQ_W-1:0] REQ_READ = 1'b1;

  // special bytes
  localparam logic [BYTE_W-1:0] BYTE_ESC   = 8'h1B;
  localparam logic [BYTE_W-1:0] BYTE_NL    = 8'h0A;
  localparam logic [BYTE_W-1:0] BYTE_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] BYTE_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] BYTE_CSI   = 8'h5B;
  localparam logic [BYTE_W-1:0] FINAL_LOW  = 8'h40;
  localparam logic [BYTE_W-1:0] FINAL_HIGH = 8'h7E;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_TEXT_ATTR = 1'b0;
  localparam logic [BYTE_W-1:0] TEXT_ATTR_RESET = 8'h0F;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_READ,
    OP_PRINT,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_SKIP
  } tcw_op_t;

  typedef struct packed {
    tcw_op_t             op;
    logic [BYTE_W-1:0]   data;
    logic [INDEX_W-1:0]  cell_index;
  } tcw_cmd_t;

  // queue status seen by the front
  typedef struct packed {
    logic full;
    logic clearing;
  } tcw_status_t;

endpackage

### rtl/tcw_if.sv
interface tcw_in_if import tcw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [BYTE_W-1:0]  byte_in;
  logic [INDEX_W-1:0] cell_index;

  modport source (output valid, output req_type, output byte_in, output cell_index,
                  input ready);
  modport sink (input valid, input req_type, input byte_in, input cell_index,
                output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] cell_char;
  logic [BYTE_W-1:0] cell_attr;
  logic [CCOL_W-1:0] cursor_col;
  logic [CROW_W-1:0] cursor_row;

  modport source (output valid, output cell_char, output cell_attr, output cursor_col,
                  output cursor_row, input ready);
  modport sink (input valid, input cell_char, input cell_attr, input cursor_col,
                input cursor_row, output ready);
endinterface

### rtl/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/tcw_front.sv
module tcw_front import tcw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  tcw_in_if.sink      in_ch,
  input  tcw_status_t status,
  output logic        push,
  output tcw_cmd_t    push_cmd
);

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_SEEN,
    ESC_CSI
  } esc_t;

  esc_t phase_r, phase_nxt;
  logic is_final;
  tcw_op_t op;

  assign in_ch.ready = !status.full && !status.clearing;
  assign push        = in_ch.valid && in_ch.ready;

  assign is_final = (in_ch.byte_in >= FINAL_LOW) && (in_ch.byte_in <= FINAL_HIGH);

  // classify the byte and track the escape sequence
  always_comb begin
    phase_nxt = phase_r;
    op        = OP_SKIP;
    if (in_ch.req_type == REQ_READ) begin
      op = OP_READ;
    end else begin
      case (phase_r)
        ESC_IDLE: begin
          if (in_ch.byte_in == BYTE_ESC) begin
            phase_nxt = ESC_SEEN;
          end else if (in_ch.byte_in == BYTE_NL) begin
            op = OP_NEWLINE;
          end else if (in_ch.byte_in == BYTE_BS) begin
            op = OP_BACKSPACE;
          end else begin
            op = OP_PRINT;
          end
        end
        ESC_SEEN: begin
          if (in_ch.byte_in == BYTE_CSI) begin
            phase_nxt = ESC_CSI;
          end else if (is_final) begin
            phase_nxt = ESC_IDLE;
          end
        end
        default: begin
          if (is_final) begin
            phase_nxt = ESC_IDLE;
          end
        end
      endcase
    end
  end

  assign push_cmd.op         = op;
  assign push_cmd.data       = in_ch.byte_in;
  assign push_cmd.cell_index = in_ch.cell_index;

  // escape phase advances only on a transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ESC_IDLE;
    end else if (push) begin
      phase_r <= phase_nxt;
    end
  end

endmodule

### rtl/tcw_fifo.sv
module tcw_fifo import tcw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  tcw_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output tcw_cmd_t head_cmd
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  tcw_cmd_t       slot_r [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  assign full       = (count_r == CW'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### rtl/tcw_back.sv
module tcw_back import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  tcw_cmd_t          q_cmd,
  output logic              q_pop,
  input  logic [BYTE_W-1:0] text_attr,
  output logic              clearing,
  tcw_out_if.source         out_ch
);

  localparam int CELLS      = COLUMNS * ROWS;
  localparam int AW         = $clog2(CELLS);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int BLANK_FROM = CELLS - COLUMNS;
  localparam logic [31:0] CELLS_LIM = CELLS;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_SCROLL,
    S_SCROLL_END
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     sweep_r, sweep_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic              cp_valid_r;
  logic [AW-1:0]     cp_dst_r;
  logic              cp_blank_r;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_char_r, out_attr_r, out_char_nxt, out_attr_nxt;
  logic [CCOL_W-1:0] out_col_r;
  logic [CROW_W-1:0] out_row_r;

  logic              out_free;
  logic              out_load;
  logic              adv_row;
  logic [AW-1:0]     cur_addr;
  logic [CELL_W-1:0] blank;
  logic              we;
  logic [AW-1:0]     wa, ra;
  logic [CELL_W-1:0] wd, rd_data;

  tcw_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_screen (
    .clk     (clk),
    .we      (we),
    .wr_addr (wa),
    .wr_data (wd),
    .rd_addr (ra),
    .rd_data (rd_data)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign q_pop    = (state_r == S_IDLE) && q_valid && out_free;
  assign cur_addr = base_r + AW'(col_r);
  assign blank    = {text_attr, BYTE_SPACE};
  assign clearing = (state_r == S_CLEAR);

  // command execution, memory port steering and sweeps
  always_comb begin
    state_nxt    = state_r;
    sweep_nxt    = sweep_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    base_nxt     = base_r;
    rd_ok_nxt    = rd_ok_r;
    out_load     = 1'b0;
    out_char_nxt = '0;
    out_attr_nxt = '0;
    adv_row      = 1'b0;
    we           = 1'b0;
    wa           = cur_addr;
    wd           = blank;
    ra           = AW'(q_cmd.cell_index);
    case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        wa = sweep_r;
        wd = '0;
        if (sweep_r == AW'(CELLS - 1)) begin
          sweep_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (q_pop) begin
          case (q_cmd.op)
            OP_READ: begin
              rd_ok_nxt = (32'(q_cmd.cell_index) < CELLS_LIM);
              state_nxt = S_READ;
            end
            OP_PRINT: begin
              we = 1'b1;
              wd = {text_attr, q_cmd.data};
              if (col_r == COL_W'(COLUMNS - 1)) begin
                col_nxt = '0;
                adv_row = 1'b1;
              end else begin
                col_nxt = col_r + 1'b1;
              end
            end
            OP_NEWLINE: begin
              col_nxt = '0;
              adv_row = 1'b1;
            end
            OP_BACKSPACE: begin
              if (col_r != '0) begin
                col_nxt = col_r - 1'b1;
                we      = 1'b1;
                wa      = cur_addr - 1'b1;
              end
            end
            default: begin
            end
          endcase
          // leaving the bottom row starts a scroll
          if (adv_row) begin
            if (row_r == ROW_W'(ROWS - 1)) begin
              sweep_nxt = '0;
              state_nxt = S_SCROLL;
            end else begin
              row_nxt  = row_r + 1'b1;
              base_nxt = base_r + AW'(COLUMNS);
            end
          end
          out_load = (q_cmd.op != OP_READ) && !(adv_row && (row_r == ROW_W'(ROWS - 1)));
        end
      end
      S_READ: begin
        out_load  = 1'b1;
        state_nxt = S_IDLE;
        if (rd_ok_r) begin
          out_char_nxt = rd_data[BYTE_W-1:0];
          out_attr_nxt = rd_data[CELL_W-1:BYTE_W];
        end
      end
      S_SCROLL: begin
        // read one row below, written in the following cycle
        ra = (sweep_r < AW'(BLANK_FROM)) ? sweep_r + AW'(COLUMNS) : '0;
        if (sweep_r == AW'(CELLS - 1)) begin
          state_nxt = S_SCROLL_END;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      S_SCROLL_END: begin
        out_load  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // delayed write stage of the scroll copy
    if (cp_valid_r) begin
      we = 1'b1;
      wa = cp_dst_r;
      wd = cp_blank_r ? blank : rd_data;
    end
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_ch.ready);

  // state, cursor and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sweep_r     <= '0;
      col_r       <= '0;
      row_r       <= '0;
      base_r      <= '0;
      cp_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      base_r      <= base_nxt;
      cp_valid_r  <= (state_r == S_SCROLL);
      out_valid_r <= out_valid_nxt;
    end
    rd_ok_r    <= rd_ok_nxt;
    cp_dst_r   <= sweep_r;
    cp_blank_r <= (sweep_r >= AW'(BLANK_FROM));
    if (out_load) begin
      out_char_r <= out_char_nxt;
      out_attr_r <= out_attr_nxt;
      out_col_r  <= CCOL_W'(col_nxt);
      out_row_r  <= CROW_W'(row_nxt);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cell_char  = out_char_r;
  assign out_ch.cell_attr  = out_attr_r;
  assign out_ch.cursor_col = out_col_r;
  assign out_ch.cursor_row = out_row_r;

endmodule

### rtl/text_console_writer_top.sv
// Text console writer: a COLUMNS x ROWS screen of char/attribute cells and a cursor.
// Input channel in_ch carries one request per transfer: req_type 0 puts byte_in
// (newline, backspace, wrap, scroll, escape sequences swallowed), req_type 1 reads
// the cell at cell_index. Every request gives exactly one result on out_ch: the
// cell read (zero for a put) and the cursor after the request.
// The front classifies bytes and tracks escape state; a two-entry command queue
// feeds the back, which owns the screen memory (one write, one read port).
// The back takes put and swallowed bytes back to back while out_ch accepts; a read
// waits on the registered memory read, and a put that scrolls holds the back while it
// copies every cell up one row through the single memory port pair and blanks the last row.
// A result passes through the command queue and then the result register.
// The text attribute register sits at byte address 0 of the APB port; write it
// only while no request is in flight.
// After reset the back clears the screen, one cell a cycle, with in_ch.ready low;
// the cursor resets to 0,0 and the attribute to 0x0F.
// When out_ch stalls, the result register holds, the queue fills, then in_ch.ready
// drops; nothing is lost.
module text_console_writer_top import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tcw_in_if.sink                in_ch,
  tcw_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [BYTE_W-1:0] text_attr_r;
  logic              cfg_write;
  tcw_status_t       status;
  logic              push, pop, full, head_valid, clearing;
  tcw_cmd_t          push_cmd, head_cmd;

  // configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_TEXT_ATTR);
  assign prdata    = (paddr[2] == REG_TEXT_ATTR) ? CFG_DATA_W'(text_attr_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_attr_r <= TEXT_ATTR_RESET;
    end else if (cfg_write) begin
      text_attr_r <= pwdata[BYTE_W-1:0];
    end
  end

  assign status.full     = full;
  assign status.clearing = clearing;

  tcw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .status   (status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  tcw_fifo u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  tcw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (head_valid),
    .q_cmd     (head_cmd),
    .q_pop     (pop),
    .text_attr (text_attr_r),
    .clearing  (clearing),
    .out_ch    (out_ch)
  );

endmodule

### rtl/tcw_checker.sv
module tcw_checker import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CCOL_W-1:0] out_cursor_col,
  input logic [CROW_W-1:0] out_cursor_row
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // the screen clear holds off input right after reset
  a_clear_blocks_input: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken during screen clear");

  // no result comes out of reset
  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // reported cursor stays on the screen
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_cursor_col) < COLUMNS) && (32'(out_cursor_row) < ROWS))
    else $error("cursor off screen");

endmodule

bind text_console_writer_top tcw_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_cursor_col (out_ch.cursor_col),
  .out_cursor_row (out_ch.cursor_row)
);
